// ===== design/pscd_pkg.sv =====
// ----------------------------------------------------------------------------
// pscd_pkg: shared types and constants of the knob scan change detector
// Item formats, panel modes, deadbands and the large-panel knob map.
// ----------------------------------------------------------------------------
package pscd_pkg;

  localparam int KnobCount    = 36;
  localparam int KnobAw       = $clog2(KnobCount);
  localparam int WarmUpPasses = 8;
  localparam int VolumeKnob   = 35;
  localparam int DeadLocked   = 32;
  localparam int DeadFree     = 8;
  localparam int DirectKnobs  = 4;
  localparam int LockKnobs    = 4;

  localparam bit VolumeExists = (VolumeKnob < KnobCount);

  typedef enum logic [1:0] {
    MODE_DIRECT = 2'd0,
    MODE_MUX    = 2'd1,
    MODE_LARGE  = 2'd2,
    MODE_HOLD   = 2'd3
  } panel_mode_e;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_LOCK   = 1'b1
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [9:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [2:0] next_adc_channel;
    logic [7:0] mux_select;
    logic       knob_event_valid;
    logic [5:0] knob_index;
    logic [9:0] knob_value;
    logic       cv_valid;
    logic [1:0] cv_index;
    logic [7:0] cv_value;
  } out_item_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] idx;
  } knob_ref_t;

  // Per-item view of the scan state, handed from sequencer to detector
  typedef struct packed {
    panel_mode_e mode;
    logic [2:0]  next_adc;
    logic [7:0]  mux;
    knob_ref_t   knob;
    logic        cv_ok;
    logic [1:0]  cv_idx;
  } seq_info_t;

  // Large-panel physical channel to logical knob
  function automatic knob_ref_t large_map(input logic [4:0] ch);
    knob_ref_t r;
    r.ok = 1'b1;
    case (ch)
      5'd0:  r.idx = 6'd33;
      5'd1:  r.idx = 6'd34;
      5'd2:  r.idx = 6'd30;
      5'd3:  r.idx = 6'd29;
      5'd4:  r.idx = 6'd24;
      5'd5:  r.idx = 6'd27;
      5'd6:  r.idx = 6'd25;
      5'd7:  r.idx = 6'd26;
      5'd8:  r.idx = 6'd22;
      5'd9:  r.idx = 6'd21;
      5'd10: r.idx = 6'd35;
      5'd11: r.idx = 6'd23;
      5'd12: r.idx = 6'd20;
      5'd16: r.idx = 6'd10;
      5'd17: r.idx = 6'd5;
      5'd18: r.idx = 6'd9;
      5'd19: r.idx = 6'd6;
      5'd20: r.idx = 6'd11;
      5'd21: r.idx = 6'd14;
      5'd22: r.idx = 6'd13;
      5'd23: r.idx = 6'd15;
      5'd24: r.idx = 6'd0;
      5'd25: r.idx = 6'd1;
      5'd26: r.idx = 6'd2;
      5'd27: r.idx = 6'd3;
      5'd28: r.idx = 6'd16;
      5'd29: r.idx = 6'd17;
      5'd30: r.idx = 6'd18;
      5'd31: r.idx = 6'd19;
      default: begin
        r.ok  = 1'b0;
        r.idx = 6'd0;
      end
    endcase
    return r;
  endfunction

  // Logical knob sampled on a given scan channel
  function automatic knob_ref_t knob_of(input logic [5:0] ch, input panel_mode_e mode);
    knob_ref_t r;
    r.ok  = 1'b0;
    r.idx = ch;
    case (mode)
      MODE_DIRECT: r.ok = (ch < 6'(DirectKnobs));
      MODE_LARGE: begin
        if (ch[5] == 1'b0) begin
          r = large_map(ch[4:0]);
        end
      end
      MODE_MUX, MODE_HOLD: r.ok = 1'b1;
      default: r.ok = 1'b0;
    endcase
    r.ok = r.ok && (7'(r.idx) < 7'(KnobCount));
    return r;
  endfunction

endpackage

// ===== design/pscd_seq.sv =====
// ----------------------------------------------------------------------------
// pscd_seq: scan sequencer
// Holds panel mode and scan position, picks the next ADC channel and mux byte.
// ----------------------------------------------------------------------------
module pscd_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  pscd_pkg::panel_mode_e cfg_mode_i,
  input  logic                 step_i,
  input  logic                 hot_we_i,
  output pscd_pkg::seq_info_t  info_o,
  output logic [5:0]           pf_addr_o
);
  import pscd_pkg::*;

  panel_mode_e mode_q, mode_d;
  logic [5:0]  scan_q, scan_d, resume_q, resume_d, hot_q, hot_d;
  logic [5:0]  scan_n, resume_n, wrapped;
  logic [6:0]  inc;
  logic [2:0]  range;
  logic [3:0]  clr;
  knob_ref_t   pf_ref;

  always_comb begin
    scan_n   = scan_q;
    resume_n = resume_q;
    wrapped  = 6'd0;
    inc      = 7'(scan_q) + 7'd1;
    range    = 3'd0;
    clr      = 4'd0;
    info_o   = '0;
    info_o.mode = mode_q;
    info_o.knob = knob_of(scan_q, mode_q);

    case (mode_q)
      MODE_DIRECT, MODE_LARGE: begin
        // alternate between the sequence and the most recently moved knob
        wrapped = (mode_q == MODE_DIRECT) ? {3'd0, inc[2:0]} : {1'b0, inc[4:0]};
        if (resume_q == 6'd0) begin
          resume_n = wrapped + 6'd1;
          scan_n   = hot_q;
        end else begin
          scan_n   = resume_q - 6'd1;
          resume_n = 6'd0;
        end
      end
      MODE_MUX: begin
        scan_n = (inc >= 7'(KnobCount) || inc > 7'd63) ? 6'd0 : inc[5:0];
      end
      default: scan_n = scan_q;
    endcase

    case (mode_q)
      MODE_MUX: begin
        if (scan_n < 6'd4) begin
          info_o.next_adc = scan_n[2:0];
        end else begin
          info_o.next_adc = 3'd4;
          info_o.mux      = {2'd0, scan_n - 6'd4};
        end
      end
      MODE_LARGE: begin
        range = scan_n[5:3];
        clr   = range[2] ? 4'd0 : (4'd1 << range[1:0]);
        info_o.mux = {~clr, scan_n[2:0], 1'b0};
      end
      default: info_o.next_adc = scan_n[2:0];
    endcase

    info_o.cv_ok  = (mode_q == MODE_DIRECT) && (scan_q >= 6'd4) && (scan_q < 6'd8);
    info_o.cv_idx = scan_q[1:0];

    scan_d   = step_i ? scan_n : scan_q;
    resume_d = step_i ? resume_n : resume_q;
    hot_d    = hot_we_i ? scan_q : hot_q;
    mode_d   = cfg_we_i ? cfg_mode_i : mode_q;
    // look up the knob of the item after this one
    pf_ref    = knob_of(scan_d, mode_d);
    pf_addr_o = pf_ref.ok ? pf_ref.idx : 6'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_DIRECT;
      scan_q   <= 6'd0;
      resume_q <= 6'd0;
      hot_q    <= 6'd0;
    end else begin
      mode_q   <= mode_d;
      scan_q   <= scan_d;
      resume_q <= resume_d;
      hot_q    <= hot_d;
    end
  end

endmodule

// ===== design/pscd_store.sv =====
// ----------------------------------------------------------------------------
// pscd_store: knob value memory
// One write and one prefetched read per cycle, with valid bits and bypass.
// ----------------------------------------------------------------------------
module pscd_store (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [5:0]  rd_addr_i,
  input  logic        wr_en_i,
  input  logic [5:0]  wr_addr_i,
  input  logic [10:0] wr_data_i,
  output logic [10:0] rd_data_o,
  output logic [10:0] vol_data_o
);
  import pscd_pkg::*;

  logic [10:0]          mem [KnobCount];
  logic [KnobCount-1:0] valid_q;
  logic [10:0]          raw_q, byp_data_q, vol_q;
  logic                 byp_q, inval_q, hit;
  logic [KnobAw-1:0]    rd_idx, wr_idx;

  assign rd_idx = rd_addr_i[KnobAw-1:0];
  assign wr_idx = wr_addr_i[KnobAw-1:0];
  assign hit    = wr_en_i && (wr_addr_i == rd_addr_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx] <= wr_data_i;
    end
    raw_q      <= mem[rd_idx];
    byp_data_q <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      byp_q   <= 1'b0;
      inval_q <= 1'b1;
      vol_q   <= '1;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_idx] <= 1'b1;
      end
      byp_q   <= hit;
      inval_q <= !hit && !valid_q[rd_idx];
      if (wr_en_i && VolumeExists && (wr_addr_i == 6'(VolumeKnob))) begin
        vol_q <= wr_data_i;
      end
    end
  end

  // never-written knobs read as minus one
  assign rd_data_o  = byp_q ? byp_data_q : (inval_q ? '1 : raw_q);
  assign vol_data_o = vol_q;

endmodule

// ===== design/pot_scan_change_detector.sv =====
// ----------------------------------------------------------------------------
// pot_scan_change_detector: knob scan sequencer and change detector
// Steers the ADC scan over the knobs and reports knob moves and CV samples.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel: one write of panel_mode, taken whenever cfg_valid_i is high.
//   in channel: one item per ADC conversion, either a sample of the channel
//     last started or a lock request for knobs 0..3.
//   out channel: exactly one item per input item; for a sample it carries the
//     next ADC channel and mux byte plus any knob event or CV sample.
//   The result is registered at the accepting edge. Throughput is one item
//   per cycle while the receiver is ready; the knob value memory is read
//   ahead from the next scan position, so its single read port sets no stall.
//   When the receiver stalls, the result register holds and in_ready_o drops
//   until the held item leaves; a new item enters in the cycle it is taken.
//   Reset starts in direct mode at channel 0 with all knobs unknown, unlocked
//   and the warm-up count loaded; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pot_scan_change_detector (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pscd_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pscd_pkg::out_item_t out_data_o
);
  import pscd_pkg::*;

  seq_info_t            info;
  logic [5:0]           pf_addr;
  logic [10:0]          stored, vol_value, wr_data;
  logic                 accept, sample_step, lock_step, wr_en, moved, warm_dec;
  logic                 warm_active, exceeds;
  logic [3:0]           warm_q, warm_d;
  logic [KnobCount-1:0] locked_q, locked_d;
  logic signed [11:0]   delta, thr;
  logic                 out_valid_q;
  out_item_t            out_q, out_d;
  logic [KnobAw-1:0]    kidx;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign sample_step = accept && (in_data_i.op == OP_SAMPLE);
  assign lock_step   = accept && (in_data_i.op == OP_LOCK);

  pscd_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i),
    .cfg_mode_i (panel_mode_e'(cfg_data_i)),
    .step_i     (sample_step),
    .hot_we_i   (sample_step && moved),
    .info_o     (info),
    .pf_addr_o  (pf_addr)
  );

  pscd_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_addr_i  (pf_addr),
    .wr_en_i    (wr_en),
    .wr_addr_i  (info.knob.idx),
    .wr_data_i  (wr_data),
    .rd_data_o  (stored),
    .vol_data_o (vol_value)
  );

  assign kidx        = info.knob.idx[KnobAw-1:0];
  assign wr_data     = {1'b0, in_data_i.sample};
  assign warm_active = (warm_q != 4'd0);
  assign delta       = $signed({2'b00, in_data_i.sample}) - $signed({stored[10], stored});
  assign thr         = locked_q[kidx] ? 12'(DeadLocked) : 12'(DeadFree);
  assign exceeds     = (delta > thr) || (delta < -thr);
  assign moved       = info.knob.ok && !warm_active && exceeds;
  assign wr_en       = sample_step && info.knob.ok && (warm_active || exceeds);
  assign warm_dec    = sample_step && info.knob.ok && warm_active && (info.knob.idx == 6'd0);

  always_comb begin
    warm_d   = warm_dec ? (warm_q - 4'd1) : warm_q;
    locked_d = locked_q;
    if (lock_step) begin
      for (int i = 0; i < LockKnobs && i < KnobCount; i++) begin
        locked_d[i] = 1'b1;
      end
    end
    if (sample_step && moved) begin
      locked_d[kidx] = 1'b0;
    end
  end

  always_comb begin
    out_d = '0;
    if (in_data_i.op == OP_SAMPLE) begin
      out_d.next_adc_channel = info.next_adc;
      out_d.mux_select       = info.mux;
      if (info.cv_ok) begin
        out_d.cv_valid = 1'b1;
        out_d.cv_index = info.cv_idx;
        out_d.cv_value = in_data_i.sample[9:2];
      end
      if (moved) begin
        out_d.knob_event_valid = 1'b1;
        out_d.knob_index       = info.knob.idx;
        out_d.knob_value       = {3'd0, in_data_i.sample[9:3]};
      end else if (warm_dec && (warm_q == 4'd1) && (info.mode == MODE_LARGE)
                   && VolumeExists) begin
        // in large mode, report the volume knob once warm-up ends
        out_d.knob_event_valid = 1'b1;
        out_d.knob_index       = 6'(VolumeKnob);
        out_d.knob_value       = vol_value[9:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warm_q      <= 4'(WarmUpPasses);
      locked_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      warm_q   <= warm_d;
      locked_q <= locked_d;
      if (in_ready_o) begin
        out_valid_q <= accept;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
